### hdl/tgi_pkg.sv
// Shared constants for the trilinear grid interpolator.
package tgi_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int IN_IDX_W  = 4;
	localparam int CNT_REG_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int KIND_W    = 3;
	localparam int NUM_BANKS = 8;

	localparam logic [CNT_REG_W-1:0] POINTS_RESET = 5'd16;

	localparam logic [KIND_W-1:0] KIND_LOAD_X = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_Y = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD_Z = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LOAD_F = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_POINTS = 2'd2;

endpackage

### hdl/tgi_bracket.sv
// Grid table of one axis with bracket search and difference stages.
module tgi_bracket #(
	parameter int MAX_POINTS = 16,
	parameter int IXW = 4
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic                                wr_en,
	input  logic [IXW-1:0]                      wr_idx,
	input  logic [tgi_pkg::DATA_W-1:0]          wr_data,
	input  logic [tgi_pkg::CNT_REG_W-1:0]       points,
	input  logic signed [tgi_pkg::DATA_W-1:0]   coord,
	output logic [IXW-1:0]                      lo,
	output logic [IXW-1:0]                      oth,
	output logic                                eq,
	output logic [tgi_pkg::DATA_W-1:0]          num,
	output logic [tgi_pkg::DATA_W-1:0]          den
);
	import tgi_pkg::*;

	localparam int CNTW = $clog2(MAX_POINTS + 1);

	logic [DATA_W-1:0] grid_q [MAX_POINTS];
	logic [CNTW-1:0] used;
	logic [MAX_POINTS-1:0] gt;
	logic [MAX_POINTS-1:0] first;
	logic [IXW-1:0] hi_idx;
	logic [IXW-1:0] lo_idx;
	logic [DATA_W-1:0] g0;
	logic [DATA_W-1:0] g1;
	logic none;

	logic [IXW-1:0] lo_s2, hi_s2, lo_s3, oth_s3;
	logic eq_s2, eq_s3;
	logic [DATA_W-1:0] g0_s2, g1_s2, c_s2, num_s3, den_s3;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_q[wr_idx] <= wr_data;
		end
	end

	always_comb begin
		if (points == '0) begin
			used = CNTW'(1);
		end else if (int'(points) > MAX_POINTS) begin
			used = CNTW'(MAX_POINTS);
		end else begin
			used = CNTW'(points);
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_POINTS; k++) begin
			gt[k] = (k < int'(used)) && ($signed(grid_q[k]) > coord);
		end
	end

	assign first = gt & (~gt + MAX_POINTS'(1));
	assign none = ~|gt;

	always_comb begin
		hi_idx = '0;
		g0 = '0;
		g1 = '0;
		for (int k = 0; k < MAX_POINTS; k++) begin
			if (first[k]) begin
				hi_idx = hi_idx | IXW'(k);
				g1 = g1 | grid_q[k];
				if (k > 0) begin
					g0 = g0 | grid_q[k-1];
				end
			end
		end
	end

	always_comb begin
		if (none) begin
			lo_idx = IXW'(used - CNTW'(1));
		end else if (first[0]) begin
			lo_idx = '0;
		end else begin
			lo_idx = hi_idx - IXW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2  <= lo_idx;
			hi_s2  <= hi_idx;
			eq_s2  <= none | first[0];
			g0_s2  <= g0;
			g1_s2  <= g1;
			c_s2   <= coord;
			lo_s3  <= lo_s2;
			oth_s3 <= eq_s2 ? (lo_s2 ^ IXW'(1)) : hi_s2;
			eq_s3  <= eq_s2;
			num_s3 <= c_s2 - g0_s2;
			den_s3 <= g1_s2 - g0_s2;
		end
	end

	assign lo = lo_s3;
	assign oth = oth_s3;
	assign eq = eq_s3;
	assign num = num_s3;
	assign den = den_s3;

endmodule

### hdl/tgi_divider.sv
// Pipelined restoring divider giving a sixteen-bit fraction, one quotient bit per stage.
module tgi_divider (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tgi_pkg::DATA_W-1:0]    num,
	input  logic [tgi_pkg::DATA_W-1:0]    den,
	output logic [tgi_pkg::FRAC_W-1:0]    quo
);
	import tgi_pkg::*;

	logic [DATA_W-1:0] rem_s [FRAC_W];
	logic [DATA_W-1:0] den_s [FRAC_W];
	logic [FRAC_W-1:0] quo_s [FRAC_W];

	for (genvar i = 0; i < FRAC_W; i++) begin : g_step
		logic [DATA_W-1:0] rem_in;
		logic [DATA_W-1:0] den_in;
		logic [FRAC_W-1:0] quo_in;
		logic [DATA_W+1:0] trial;
		logic [DATA_W+1:0] diff;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {1'b0, rem_in, 1'b0};
		assign diff = trial - {2'b00, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[DATA_W+1]) begin
					rem_s[i] <= diff[DATA_W-1:0];
					quo_s[i] <= {quo_in[FRAC_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= trial[DATA_W-1:0];
					quo_s[i] <= {quo_in[FRAC_W-2:0], 1'b0};
				end
				den_s[i] <= den_in;
			end
		end
	end

	assign quo = quo_s[FRAC_W-1];

endmodule

### hdl/tgi_blend.sv
// Two-stage linear blend of two Q16.16 values with a Q0.16 weight, rounded to nearest.
module tgi_blend (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [tgi_pkg::DATA_W-1:0]   v0,
	input  logic signed [tgi_pkg::DATA_W-1:0]   v1,
	input  logic [tgi_pkg::FRAC_W-1:0]          r,
	output logic signed [tgi_pkg::DATA_W-1:0]   res
);
	import tgi_pkg::*;

	localparam int PW = DATA_W + FRAC_W + 2;
	localparam logic [PW:0] RND = (PW+1)'(1) << (FRAC_W - 1);

	logic [FRAC_W:0] w;
	logic signed [PW-1:0] prod0;
	logic signed [PW-1:0] prod1;
	logic signed [PW-1:0] p0_s1;
	logic signed [PW-1:0] p1_s1;
	logic [PW:0] sum;
	logic signed [DATA_W-1:0] res_s2;

	assign w = {1'b1, {FRAC_W{1'b0}}} - {1'b0, r};
	assign prod0 = v0 * $signed({1'b0, w});
	assign prod1 = v1 * $signed({2'b00, r});

	// A zero weight leaves the upper value out entirely.
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= prod0;
			p1_s1 <= (r == '0) ? '0 : prod1;
			res_s2 <= sum[FRAC_W +: DATA_W];
		end
	end

	assign sum = (PW+1)'(p0_s1) + (PW+1)'(p1_s1) + RND;
	assign res = res_s2;

endmodule

### hdl/tgi_fstore.sv
// Field store in eight banks split by index parity, one read per bank each cycle that en is high.
module tgi_fstore #(
	parameter int AW = 9
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          we,
	input  logic [2:0]                    wbank,
	input  logic [AW-1:0]                 waddr,
	input  logic [tgi_pkg::DATA_W-1:0]    wdata,
	input  logic [AW-1:0]                 raddr [tgi_pkg::NUM_BANKS],
	output logic [tgi_pkg::DATA_W-1:0]    rdata [tgi_pkg::NUM_BANKS]
);
	import tgi_pkg::*;

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [DATA_W-1:0] mem [2**AW];

		always_ff @(posedge clk) begin
			if (en) begin
				if (we && (wbank == 3'(b))) begin
					mem[waddr] <= wdata;
				end
				rdata[b] <= mem[raddr[b]];
			end
		end
	end

endmodule

### hdl/trilinear_grid_interpolator_core.sv
// Top level of the trilinear interpolator over a non-uniform grid.
// One transaction is accepted per clock cycle while the result output is not held, loads and
// queries alike. After acceptance a query passes through the input register, the bracket search
// and difference stages, the 16-stage restoring divider per axis, the field store read and the
// blends along z, then y, then x. The eight-bank field store serves all eight corners together,
// so corner reads never hold the rate below one transaction per cycle. A held result stalls the
// whole pipeline. Grid and field entries have no reset and must be loaded before a query uses
// them; there is no clearing pass.
module trilinear_grid_interpolator_core #(
	parameter int MAX_X_POINTS = 16,
	parameter int MAX_Y_POINTS = 16,
	parameter int MAX_Z_POINTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tgi_pkg::KIND_W-1:0]          kind,
	input  logic [tgi_pkg::IN_IDX_W-1:0]        x_index,
	input  logic [tgi_pkg::IN_IDX_W-1:0]        y_index,
	input  logic [tgi_pkg::IN_IDX_W-1:0]        z_index,
	input  logic signed [tgi_pkg::DATA_W-1:0]   load_value,
	input  logic signed [tgi_pkg::DATA_W-1:0]   query_x,
	input  logic signed [tgi_pkg::DATA_W-1:0]   query_y,
	input  logic signed [tgi_pkg::DATA_W-1:0]   query_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tgi_pkg::DATA_W-1:0]   interpolated,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tgi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tgi_pkg::CNT_REG_W-1:0]       cfg_data
);
	import tgi_pkg::*;

	localparam int XIW = ($clog2(MAX_X_POINTS) < 2) ? 2 : $clog2(MAX_X_POINTS);
	localparam int YIW = ($clog2(MAX_Y_POINTS) < 2) ? 2 : $clog2(MAX_Y_POINTS);
	localparam int ZIW = ($clog2(MAX_Z_POINTS) < 2) ? 2 : $clog2(MAX_Z_POINTS);
	localparam int AW = XIW + YIW + ZIW - 3;
	localparam int DSTG = FRAC_W;

	typedef struct packed {
		logic              fwr;
		logic [2:0]        wbank;
		logic [AW-1:0]     waddr;
		logic [DATA_W-1:0] wdata;
	} mem_op_t;

	typedef struct packed {
		logic           query;
		mem_op_t        mop;
		logic [XIW-1:0] lox;
		logic [XIW-1:0] othx;
		logic           eqx;
		logic [YIW-1:0] loy;
		logic [YIW-1:0] othy;
		logic           eqy;
		logic [ZIW-1:0] loz;
		logic [ZIW-1:0] othz;
		logic           eqz;
	} trk_t;

	logic adv;
	logic accept;
	logic [CNT_REG_W-1:0] x_points_q, y_points_q, z_points_q;

	logic vld_s1, vld_s2, vld_s3;
	logic [KIND_W-1:0] kind_s1;
	logic [IN_IDX_W-1:0] xi_s1, yi_s1, zi_s1;
	logic [XIW-1:0] wx_s1;
	logic [YIW-1:0] wy_s1;
	logic [ZIW-1:0] wz_s1;
	logic [DATA_W-1:0] val_s1;
	logic signed [DATA_W-1:0] qx_s1, qy_s1, qz_s1;
	logic qry_s2, qry_s3;
	mem_op_t mop_s1, mop_s2, mop_s3;

	logic [XIW-1:0] lox_s3, othx_s3;
	logic [YIW-1:0] loy_s3, othy_s3;
	logic [ZIW-1:0] loz_s3, othz_s3;
	logic eqx_s3, eqy_s3, eqz_s3;
	logic [DATA_W-1:0] numx, denx, numy, deny, numz, denz;
	logic [FRAC_W-1:0] quox, quoy, quoz;

	logic vld_d [DSTG];
	trk_t trk_d [DSTG];
	trk_t tl;

	logic [AW-1:0] raddr [NUM_BANKS];
	logic [DATA_W-1:0] rdata [NUM_BANKS];
	logic [DATA_W-1:0] corner [NUM_BANKS];

	logic qv_s20, qv_s21, qv_s22, qv_s23, qv_s24, qv_s25, qv_s26;
	logic px_s20, py_s20, pz_s20;
	logic [FRAC_W-1:0] rx_s20, ry_s20, rz_s20;
	logic [FRAC_W-1:0] rx_s21, rx_s22, rx_s23, rx_s24, ry_s21, ry_s22;
	logic signed [DATA_W-1:0] a00, a01, a10, a11, b0, b1;

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign accept = in_valid && adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_points_q <= POINTS_RESET;
			y_points_q <= POINTS_RESET;
			z_points_q <= POINTS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_X_POINTS: x_points_q <= cfg_data;
				CFG_Y_POINTS: y_points_q <= cfg_data;
				CFG_Z_POINTS: z_points_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			xi_s1   <= x_index;
			yi_s1   <= y_index;
			zi_s1   <= z_index;
			val_s1  <= load_value;
			qx_s1   <= query_x;
			qy_s1   <= query_y;
			qz_s1   <= query_z;
			qry_s2  <= kind_s1 == KIND_QUERY;
			mop_s2  <= mop_s1;
			qry_s3  <= qry_s2;
			mop_s3  <= mop_s2;
		end
	end

	assign wx_s1 = XIW'(xi_s1);
	assign wy_s1 = YIW'(yi_s1);
	assign wz_s1 = ZIW'(zi_s1);

	// Field loads are carried down to the store so that they stay in order with queries.
	always_comb begin
		mop_s1.fwr = (kind_s1 == KIND_LOAD_F) && (int'(xi_s1) < MAX_X_POINTS) &&
			(int'(yi_s1) < MAX_Y_POINTS) && (int'(zi_s1) < MAX_Z_POINTS);
		mop_s1.wbank = {xi_s1[0], yi_s1[0], zi_s1[0]};
		mop_s1.waddr = {wx_s1[XIW-1:1], wy_s1[YIW-1:1], wz_s1[ZIW-1:1]};
		mop_s1.wdata = val_s1;
	end

	tgi_bracket #(.MAX_POINTS(MAX_X_POINTS), .IXW(XIW)) u_brk_x (
		.clk(clk), .en(adv),
		.wr_en(accept && (kind == KIND_LOAD_X) && (int'(x_index) < MAX_X_POINTS)),
		.wr_idx(XIW'(x_index)), .wr_data(load_value), .points(x_points_q), .coord(qx_s1),
		.lo(lox_s3), .oth(othx_s3), .eq(eqx_s3), .num(numx), .den(denx)
	);

	tgi_bracket #(.MAX_POINTS(MAX_Y_POINTS), .IXW(YIW)) u_brk_y (
		.clk(clk), .en(adv),
		.wr_en(accept && (kind == KIND_LOAD_Y) && (int'(y_index) < MAX_Y_POINTS)),
		.wr_idx(YIW'(y_index)), .wr_data(load_value), .points(y_points_q), .coord(qy_s1),
		.lo(loy_s3), .oth(othy_s3), .eq(eqy_s3), .num(numy), .den(deny)
	);

	tgi_bracket #(.MAX_POINTS(MAX_Z_POINTS), .IXW(ZIW)) u_brk_z (
		.clk(clk), .en(adv),
		.wr_en(accept && (kind == KIND_LOAD_Z) && (int'(z_index) < MAX_Z_POINTS)),
		.wr_idx(ZIW'(z_index)), .wr_data(load_value), .points(z_points_q), .coord(qz_s1),
		.lo(loz_s3), .oth(othz_s3), .eq(eqz_s3), .num(numz), .den(denz)
	);

	tgi_divider u_div_x (.clk(clk), .en(adv), .num(numx), .den(denx), .quo(quox));
	tgi_divider u_div_y (.clk(clk), .en(adv), .num(numy), .den(deny), .quo(quoy));
	tgi_divider u_div_z (.clk(clk), .en(adv), .num(numz), .den(denz), .quo(quoz));

	for (genvar i = 0; i < DSTG; i++) begin : g_trk
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[i] <= 1'b0;
			end else if (adv) begin
				vld_d[i] <= (i == 0) ? vld_s3 : vld_d[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (i == 0) begin
					trk_d[i] <= '{query: qry_s3, mop: mop_s3,
						lox: lox_s3, othx: othx_s3, eqx: eqx_s3,
						loy: loy_s3, othy: othy_s3, eqy: eqy_s3,
						loz: loz_s3, othz: othz_s3, eqz: eqz_s3};
				end else begin
					trk_d[i] <= trk_d[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	assign tl = trk_d[DSTG-1];

	// The bank whose parity matches the lower corner holds it; the other bank holds the other corner.
	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			raddr[b] = {
				((b[2] == tl.lox[0]) ? tl.lox[XIW-1:1] : tl.othx[XIW-1:1]),
				((b[1] == tl.loy[0]) ? tl.loy[YIW-1:1] : tl.othy[YIW-1:1]),
				((b[0] == tl.loz[0]) ? tl.loz[ZIW-1:1] : tl.othz[ZIW-1:1])
			};
		end
	end

	tgi_fstore #(.AW(AW)) u_fstore (
		.clk(clk), .en(adv), .we(vld_d[DSTG-1] && tl.mop.fwr),
		.wbank(tl.mop.wbank), .waddr(tl.mop.waddr), .wdata(tl.mop.wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s20 <= 1'b0;
			qv_s21 <= 1'b0;
			qv_s22 <= 1'b0;
			qv_s23 <= 1'b0;
			qv_s24 <= 1'b0;
			qv_s25 <= 1'b0;
			qv_s26 <= 1'b0;
		end else if (adv) begin
			qv_s20 <= vld_d[DSTG-1] && tl.query;
			qv_s21 <= qv_s20;
			qv_s22 <= qv_s21;
			qv_s23 <= qv_s22;
			qv_s24 <= qv_s23;
			qv_s25 <= qv_s24;
			qv_s26 <= qv_s25;
		end
	end

	// A clamped axis blends its other corner with a zero weight, which gives the lower corner's value.
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s20 <= tl.lox[0];
			py_s20 <= tl.loy[0];
			pz_s20 <= tl.loz[0];
			rx_s20 <= tl.eqx ? '0 : quox;
			ry_s20 <= tl.eqy ? '0 : quoy;
			rz_s20 <= tl.eqz ? '0 : quoz;
			rx_s21 <= rx_s20;
			rx_s22 <= rx_s21;
			rx_s23 <= rx_s22;
			rx_s24 <= rx_s23;
			ry_s21 <= ry_s20;
			ry_s22 <= ry_s21;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_BANKS; c++) begin
			corner[c] = rdata[3'(c) ^ {px_s20, py_s20, pz_s20}];
		end
	end

	tgi_blend u_bz00 (.clk(clk), .en(adv), .v0(corner[0]), .v1(corner[1]), .r(rz_s20),
		.res(a00));
	tgi_blend u_bz01 (.clk(clk), .en(adv), .v0(corner[2]), .v1(corner[3]), .r(rz_s20),
		.res(a01));
	tgi_blend u_bz10 (.clk(clk), .en(adv), .v0(corner[4]), .v1(corner[5]), .r(rz_s20),
		.res(a10));
	tgi_blend u_bz11 (.clk(clk), .en(adv), .v0(corner[6]), .v1(corner[7]), .r(rz_s20),
		.res(a11));
	tgi_blend u_by0 (.clk(clk), .en(adv), .v0(a00), .v1(a01), .r(ry_s22), .res(b0));
	tgi_blend u_by1 (.clk(clk), .en(adv), .v0(a10), .v1(a11), .r(ry_s22), .res(b1));
	tgi_blend u_bx (.clk(clk), .en(adv), .v0(b0), .v1(b1), .r(rx_s24), .res(interpolated));

	assign out_valid = qv_s26;

`ifndef ASSERT_OFF
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("Input stalled without a pending result transaction.");

	a_corner_banks_differ: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && qry_s3 |-> (lox_s3[0] != othx_s3[0]) && (loy_s3[0] != othy_s3[0]) &&
		(loz_s3[0] != othz_s3[0]))
		else $error("Corner pair maps to a single field bank.");

	a_store_op_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_d[DSTG-1] && tl.query |-> !tl.mop.fwr)
		else $error("Field store written and read by one transaction.");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(qv_s25 && adv))
		else $error("Result appeared without a query in the last blend stage.");
`endif

endmodule
